// ===== src/lcd_scanout_grayscale_assert.svh =====
// assertion macros used by the checker file
`ifndef LCD_SCANOUT_GRAYSCALE_ASSERT_SVH
`define LCD_SCANOUT_GRAYSCALE_ASSERT_SVH

// same-cycle implication, disabled while reset is applied
`define LSG_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lsg assertion failed");

// next-cycle implication, disabled while reset is applied
`define LSG_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lsg assertion failed");

`endif

// ===== src/lsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsg_pkg
// Shared constants and types of the grayscale LCD scan-out controller.
// ----------------------------------------------------------------------------
package lsg_pkg;

	localparam int PANEL_WIDTH  = 131;
	localparam int PANEL_HEIGHT = 64;
	localparam int PLANE_SIZE   = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int IDX_W        = $clog2(PLANE_SIZE);
	localparam int ADDR_W       = 20;
	localparam int CNT_W        = $clog2((PANEL_WIDTH + 6) / 4 + 2);
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_W      = $clog2(Q_DEPTH);

	localparam logic [ADDR_W-1:0] ROW_ADVANCE = 20'h00022;

	// configuration register indexes
	localparam logic [2:0] CFG_SCREEN_BASE = 3'd0;
	localparam logic [2:0] CFG_MENU_AREA   = 3'd1;
	localparam logic [2:0] CFG_STRIDE      = 3'd2;
	localparam logic [2:0] CFG_MAIN_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_PIXEL_SHIFT = 3'd4;

	// command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_NIBBLE = 1'b1;

	typedef struct packed {
		logic       command;
		logic       enable_display;
		logic [3:0] nibble_data;
	} item_t;

	typedef struct packed {
		logic [19:0] fetch_address;
		logic [5:0]  fetch_count;
		logic [5:0]  line_index;
		logic        menu_line;
		logic        frame_done;
		logic        pixel_valid;
		logic [7:0]  column;
		logic        pixel_lit;
		logic [1:0]  gray_level;
		logic        last;
	} result_t;

	// work entry from front to back
	typedef struct packed {
		result_t          res;
		logic [IDX_W-1:0] idx;
		logic             gray_en;
	} entry_t;

	// per-pixel history word
	typedef struct packed {
		logic [1:0] gray;
		logic       prev;
		logic       cur;
	} hist_t;

endpackage

// ===== src/lsg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsg_front
// Row sequencing, configuration registers and nibble to pixel expansion.
// ----------------------------------------------------------------------------
module lsg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  lsg_pkg::item_t        item,
	output logic                  busy,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [19:0]           cfg_data,
	output logic                  q_push,
	output lsg_pkg::entry_t       q_data,
	input  logic                  q_full
);
	import lsg_pkg::*;

	logic [ADDR_W-1:0] screen_base_q, menu_area_q;
	logic [11:0]       stride_q;
	logic [5:0]        main_height_q;
	logic [2:0]        pixel_shift_q;

	logic [ADDR_W-1:0] scan_addr_q;
	logic [5:0]        row_q;
	logic              menu_q, doff_q, gray_on_q;
	logic [1:0]        fphase_q;
	logic [7:0]        col_q;
	logic [CNT_W-1:0]  ncnt_q, left_q;
	logic [5:0]        rowl_q;
	logic              menul_q, grayl_q, skipl_q;
	logic [1:0]        sbl_q;
	logic              busy_q;
	logic [3:0]        data_q;
	logic [1:0]        bit_q;

	logic              doff_n, menu_a, menu_n, skip, done, gray_on_n;
	logic [5:0]        row_a, row_n;
	logic [6:0]        row_inc;
	logic [ADDR_W-1:0] addr_a, next_addr;
	logic [2:0]        shift;
	logic [8:0]        cnt_sum;
	logic [CNT_W-1:0]  count;
	logic [1:0]        fphase_n;
	logic              is_tick, emit, pix_last;
	logic [IDX_W-1:0]  pix_idx;

	assign is_tick = (item.command == CMD_TICK);
	assign emit    = busy_q && !q_full;
	assign busy    = busy_q;

	// line tick evaluation
	always_comb begin
		doff_n = doff_q;
		row_a  = row_q;
		menu_a = menu_q;
		addr_a = scan_addr_q;
		if (!item.enable_display && !doff_q) begin
			doff_n = 1'b1;
			row_a  = '0;
		end else if (item.enable_display && doff_q) begin
			doff_n = 1'b0;
			row_a  = '0;
			menu_a = 1'b0;
			addr_a = screen_base_q;
		end
		shift   = menu_a ? 3'd0 : pixel_shift_q;
		skip    = shift[2];
		cnt_sum = 9'(shift[1:0]) + 9'(PANEL_WIDTH + 3);
		count   = CNT_W'(cnt_sum >> 2) + CNT_W'(skip);
		next_addr = addr_a + ROW_ADVANCE;
		if (!menu_a) begin
			next_addr = next_addr + {18'd0, pixel_shift_q[2], 1'b0}
				+ {{8{stride_q[11]}}, stride_q};
		end
		menu_n = menu_a;
		if (row_a == main_height_q) begin
			menu_n    = 1'b1;
			next_addr = menu_area_q;
		end
		row_inc  = 7'(row_a) + 7'd1;
		done     = (row_inc >= 7'(PANEL_HEIGHT));
		fphase_n = fphase_q;
		row_n    = row_inc[5:0];
		if (done) begin
			row_n     = '0;
			menu_n    = 1'b0;
			next_addr = screen_base_q;
			fphase_n  = (fphase_q >= 2'd2) ? 2'd0 : fphase_q + 2'd1;
		end
		gray_on_n = (fphase_n == 2'd0);
	end

	// pixel beat fields
	assign pix_last = (bit_q == 2'd3) || (col_q == 8'(PANEL_WIDTH - 1));
	assign pix_idx  = IDX_W'(col_q) + IDX_W'(rowl_q) * IDX_W'(PANEL_WIDTH);

	// queue entry
	always_comb begin
		q_data = '0;
		q_push = 1'b0;
		if (accept && is_tick) begin
			q_push = 1'b1;
			q_data.res.last = 1'b1;
			if (!doff_n) begin
				q_data.res.fetch_address = addr_a;
				q_data.res.fetch_count   = 6'(count);
				q_data.res.line_index    = row_a;
				q_data.res.menu_line     = menu_a;
				q_data.res.frame_done    = done;
			end
		end else if (emit) begin
			q_push = 1'b1;
			q_data.res.line_index  = rowl_q;
			q_data.res.menu_line   = menul_q;
			q_data.res.pixel_valid = 1'b1;
			q_data.res.column      = col_q;
			q_data.res.pixel_lit   = data_q[bit_q];
			q_data.res.last        = pix_last;
			q_data.idx             = pix_idx;
			q_data.gray_en         = grayl_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_base_q <= '0;
			menu_area_q   <= '0;
			stride_q      <= '0;
			main_height_q <= 6'd63;
			pixel_shift_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SCREEN_BASE: screen_base_q <= cfg_data;
				CFG_MENU_AREA:   menu_area_q   <= cfg_data;
				CFG_STRIDE:      stride_q      <= cfg_data[11:0];
				CFG_MAIN_HEIGHT: main_height_q <= cfg_data[5:0];
				CFG_PIXEL_SHIFT: pixel_shift_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// row state and nibble expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			row_q       <= '0;
			menu_q      <= 1'b0;
			doff_q      <= 1'b0;
			gray_on_q   <= 1'b0;
			fphase_q    <= '0;
			col_q       <= '0;
			ncnt_q      <= '0;
			left_q      <= '0;
			rowl_q      <= '0;
			menul_q     <= 1'b0;
			grayl_q     <= 1'b0;
			skipl_q     <= 1'b0;
			sbl_q       <= '0;
			busy_q      <= 1'b0;
			data_q      <= '0;
			bit_q       <= '0;
		end else begin
			if (accept && is_tick) begin
				doff_q <= doff_n;
				if (doff_n) begin
					row_q  <= row_a;
					left_q <= '0;
				end else begin
					rowl_q      <= row_a;
					menul_q     <= menu_a;
					grayl_q     <= gray_on_q;
					skipl_q     <= skip;
					sbl_q       <= shift[1:0];
					col_q       <= '0;
					ncnt_q      <= '0;
					left_q      <= count;
					scan_addr_q <= next_addr;
					row_q       <= row_n;
					menu_q      <= menu_n;
					fphase_q    <= fphase_n;
					gray_on_q   <= gray_on_n;
				end
			end else if (accept && left_q != '0) begin
				ncnt_q <= ncnt_q + CNT_W'(1);
				left_q <= left_q - CNT_W'(1);
				if (!(skipl_q && ncnt_q == '0) && col_q < 8'(PANEL_WIDTH)) begin
					busy_q <= 1'b1;
					data_q <= item.nibble_data;
					bit_q  <= (ncnt_q == CNT_W'(skipl_q)) ? sbl_q : 2'd0;
				end
			end
			if (emit) begin
				col_q <= col_q + 8'd1;
				if (pix_last)
					busy_q <= 1'b0;
				else
					bit_q <= bit_q + 2'd1;
			end
		end
	end

endmodule

// ===== src/lsg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsg_queue
// Small work queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsg_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output lsg_pkg::entry_t rdata,
	output logic            empty
);
	import lsg_pkg::*;

	entry_t             buf_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q, rp_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + Q_PTR_W'(1);
			if (pop)
				rp_q <= rp_q + Q_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (Q_PTR_W + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (Q_PTR_W + 1)'(1);
		end
	end

endmodule

// ===== src/lsg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsg_back
// Frame history read-modify-write and result queue.
// ----------------------------------------------------------------------------
module lsg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  lsg_pkg::entry_t  q_data,
	output logic             q_pop,
	output logic             clearing,
	output logic             empty,
	input  logic             pop,
	output lsg_pkg::result_t result
);
	import lsg_pkg::*;

	hist_t            mem [PLANE_SIZE];
	hist_t            rd_q, wlast_q, old_w, new_w;
	entry_t           s1_q;
	logic             s1_v_q, byp_s1;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             s1_adv, s1_wr;
	result_t          res;

	result_t          ob_q [2];
	logic             owp_q, orp_q;
	logic [1:0]       ocnt_q;
	logic             ofull;

	assign ofull    = (ocnt_q == 2'd2);
	assign empty    = (ocnt_q == 2'd0);
	assign result   = ob_q[orp_q];
	assign clearing = clr_busy_q;

	assign s1_adv = s1_v_q && !ofull;
	assign s1_wr  = s1_adv && s1_q.res.pixel_valid;
	assign q_pop  = !clr_busy_q && !q_empty && (!s1_v_q || s1_adv);

	// history update
	always_comb begin
		old_w     = byp_s1 ? wlast_q : rd_q;
		new_w.cur = s1_q.res.pixel_lit;
		new_w.prev = old_w.cur;
		new_w.gray = s1_q.gray_en
			? 2'(old_w.prev) + 2'(old_w.cur) + 2'(s1_q.res.pixel_lit) : old_w.gray;
		res = s1_q.res;
		if (s1_q.res.pixel_valid)
			res.gray_level = new_w.gray;
	end

	// history memory
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_cnt_q] <= '0;
		else if (s1_wr)
			mem[s1_q.idx] <= new_w;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			rd_q <= mem[q_data.idx];
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			s1_q   <= q_data;
			byp_s1 <= s1_wr && (s1_q.idx == q_data.idx);
		end
		if (s1_wr)
			wlast_q <= new_w;
		if (s1_adv)
			ob_q[owp_q] <= res;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			owp_q      <= 1'b0;
			orp_q      <= 1'b0;
			ocnt_q     <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
				if (clr_cnt_q == IDX_W'(PLANE_SIZE - 1))
					clr_busy_q <= 1'b0;
			end
			if (q_pop)
				s1_v_q <= 1'b1;
			else if (s1_adv)
				s1_v_q <= 1'b0;
			if (s1_adv)
				owp_q <= ~owp_q;
			if (pop && !empty)
				orp_q <= ~orp_q;
			if (s1_adv && !(pop && !empty))
				ocnt_q <= ocnt_q + 2'd1;
			else if (!s1_adv && pop && !empty)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

endmodule

// ===== src/lcd_scanout_grayscale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanout_grayscale
// Nibble-mapped LCD scan-out controller with three-frame grayscale.
// ----------------------------------------------------------------------------
// A line tick is taken and gives one result. A memory nibble is taken and
// then expanded into its pixels at one per cycle while the work queue is not
// full, so a nibble holds the input until its last pixel (up to four) is queued;
// the pixel rate is set by the history memory, which has one read and one
// write port and does one read-modify-write per cycle unless the result buffer
// is full. After reset the history memory is cleared, one entry per cycle, all
// 8384 entries, while full stays high.
module lcd_scanout_grayscale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  lsg_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output lsg_pkg::result_t result,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [19:0]      cfg_data
);
	import lsg_pkg::*;

	logic   accept, front_busy, clearing;
	logic   q_push, q_full, q_pop, q_empty;
	entry_t q_wdata, q_rdata;

	assign full   = front_busy || q_full || clearing;
	assign accept = push && !full;

	lsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.busy      (front_busy),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	lsg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	lsg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== src/lsg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsg_checker
// Port-level checks of the scan-out controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_scanout_grayscale_assert.svh"

module lsg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input lsg_pkg::result_t result
);
	import lsg_pkg::*;

	// pixel beats carry no fetch information
	`LSG_ASSERT_IMPLY(a_pixel_no_fetch, clk, arst_n, !empty && result.pixel_valid, result.fetch_count == 6'd0 && !result.frame_done && result.fetch_address == 20'd0)

	// a tick gives exactly one beat
	`LSG_ASSERT_IMPLY(a_tick_last, clk, arst_n, !empty && !result.pixel_valid, result.last)

	// a waiting beat stays until taken
	`LSG_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// handshake flags always known out of reset
	`LSG_ASSERT_IMPLY(a_flags_known, clk, arst_n, 1'b1, !$isunknown({full, empty}))

endmodule

bind lcd_scanout_grayscale lsg_checker u_lsg_checker (.*);
